@@ sv/hcf_pkg.sv @@
`timescale 1ns / 1ps

package hcf_pkg;

   localparam logic [1:0] FUNC_HOST = 2'd0;
   localparam logic [1:0] FUNC_GET  = 2'd1;
   localparam logic [1:0] FUNC_PUT  = 2'd2;

   localparam logic [4:0] XFER_MAX = 5'd16;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [4:0] FREE_SAT = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic [3:0] slot;
   } pack_ctl_type;

endpackage

@@ sv/hcf_ram.sv @@
`timescale 1ns / 1ps

module hcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/hcf_pack.sv @@
`timescale 1ns / 1ps

module hcf_pack (
   input  logic                 clock,
   input  hcf_pkg::pack_ctl_type ctl,
   input  logic [7:0]           byte_in,
   output logic [63:0]          word_high,
   output logic [63:0]          word_low
);

   logic [127:0] word_ff;
   logic [127:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.clear) begin
         word_in = '0;
      end else if (ctl.push) begin
         // slot 0 lands in the top byte: top bit is 127 - 8 * slot
         word_in[{~ctl.slot, 3'b111} -: 8] = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_high = word_ff[127:64];
   assign word_low  = word_ff[63:0];

endmodule

@@ sv/hypervisor_console_fifo_unit.sv @@
`timescale 1ns / 1ps
// Host byte, put and unused functions register their result; it shows in the cycle after accept.
// A get on an empty ring also answers in the cycle after accept; otherwise it enters the drain
// state and stays there until the transfer is full, the ring is empty or it stops before a zero
// held back after a carriage return, one ring read per cycle through the RAM read port.
// Throughput: busy is high only while a get drains; other items go back to back.
// Reset clears the ring pointers and fill count; ring contents are not cleared.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.

module hypervisor_console_fifo_unit #(
   parameter int RING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_put_count,
   input  logic [63:0] req_put_word_high,
   input  logic [63:0] req_put_word_low,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic        rsp_irq_pulse,
   output logic        rsp_byte_dropped,
   output logic [4:0]  rsp_free_space,
   output logic [4:0]  rsp_got_count,
   output logic [63:0] rsp_got_word_high,
   output logic [63:0] rsp_got_word_low,
   output logic        rsp_tx_valid,
   output logic [4:0]  rsp_tx_count,
   output logic [63:0] rsp_tx_word_high,
   output logic [63:0] rsp_tx_word_low
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int OW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic [OW-1:0] DEPTH_OW  = OW'(RING_DEPTH);
   localparam logic [OW-1:0] ONE_OW    = OW'(1);

   hcf_pkg::state_type state_ff, state_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [OW-1:0] used_ff, used_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          last_cr_ff, last_cr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        status_ff, status_in;
   logic        irq_ff, irq_in;
   logic        drop_ff, drop_in;
   logic [4:0]  free_ff, free_in;
   logic [4:0]  got_cnt_ff, got_cnt_in;
   logic        got_sel_ff, got_sel_in;
   logic        tx_valid_ff, tx_valid_in;
   logic [4:0]  tx_cnt_ff, tx_cnt_in;
   logic [63:0] tx_hi_ff, tx_hi_in;
   logic [63:0] tx_lo_ff, tx_lo_in;

   logic        accept;
   logic        ram_we;
   logic [7:0]  ram_rdata;
   logic        take;
   logic [OW-1:0]   free_full;
   logic [OW+4:0]   free_ext;
   logic [63:0] pack_hi, pack_lo;
   hcf_pkg::pack_ctl_type pack_ctl;

   assign accept = start && !busy;
   assign busy   = (state_ff != hcf_pkg::ST_IDLE);
   assign take   = !((cnt_ff != 5'd0) && last_cr_ff && (ram_rdata == hcf_pkg::CH_NUL));

   // free entries after this item, saturated to the port width
   assign free_full = DEPTH_OW - used_in;
   assign free_ext  = (OW + 5)'(free_full);
   assign free_in   = (free_ext > (OW + 5)'(hcf_pkg::FREE_SAT)) ? hcf_pkg::FREE_SAT
                                                                : free_ext[4:0];

   always_comb begin
      state_in     = state_ff;
      wr_addr_in   = wr_addr_ff;
      rd_addr_in   = rd_addr_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      last_cr_in   = last_cr_ff;
      ram_we       = 1'b0;
      pack_ctl     = '0;
      rsp_valid_in = 1'b0;
      status_in    = 1'b0;
      irq_in       = 1'b0;
      drop_in      = 1'b0;
      got_cnt_in   = 5'd0;
      got_sel_in   = got_sel_ff;
      tx_valid_in  = 1'b0;
      tx_cnt_in    = 5'd0;
      tx_hi_in     = 64'd0;
      tx_lo_in     = 64'd0;

      unique case (state_ff)
         hcf_pkg::ST_IDLE: begin
            if (accept) begin
               got_sel_in = 1'b0;
               unique case (req_func)
                  hcf_pkg::FUNC_HOST: begin
                     rsp_valid_in = 1'b1;
                     if (used_ff == DEPTH_OW) begin
                        drop_in = 1'b1;
                     end else begin
                        irq_in     = (used_ff == '0);
                        ram_we     = 1'b1;
                        wr_addr_in = (wr_addr_ff == LAST_ADDR) ? '0 : wr_addr_ff + 1'b1;
                        used_in    = used_ff + ONE_OW;
                     end
                  end
                  hcf_pkg::FUNC_GET: begin
                     pack_ctl.clear = 1'b1;
                     cnt_in         = 5'd0;
                     last_cr_in     = 1'b0;
                     if (used_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        got_sel_in   = 1'b1;
                     end else begin
                        state_in = hcf_pkg::ST_DRAIN;
                     end
                  end
                  hcf_pkg::FUNC_PUT: begin
                     rsp_valid_in = 1'b1;
                     if (req_put_count > 8'(hcf_pkg::XFER_MAX)) begin
                        status_in = 1'b1;
                     end else begin
                        tx_valid_in = 1'b1;
                        tx_cnt_in   = req_put_count[4:0];
                        tx_hi_in    = req_put_word_high;
                        tx_lo_in    = req_put_word_low;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         hcf_pkg::ST_DRAIN: begin
            if (take) begin
               pack_ctl.push = 1'b1;
               pack_ctl.slot = cnt_ff[3:0];
               cnt_in        = cnt_ff + 5'd1;
               last_cr_in    = (ram_rdata == hcf_pkg::CH_CR);
               rd_addr_in    = (rd_addr_ff == LAST_ADDR) ? '0 : rd_addr_ff + 1'b1;
               used_in       = used_ff - ONE_OW;
            end
            // stop on a held-back zero, a full transfer or an empty ring
            if (!take || (cnt_ff == hcf_pkg::XFER_MAX - 5'd1) || (used_ff == ONE_OW)) begin
               state_in     = hcf_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               got_sel_in   = 1'b1;
               got_cnt_in   = cnt_in;
            end
         end
         default: begin
            state_in = hcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcf_pkg::ST_IDLE;
         wr_addr_ff   <= '0;
         rd_addr_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_addr_ff   <= wr_addr_in;
         rd_addr_ff   <= rd_addr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      last_cr_ff  <= last_cr_in;
      status_ff   <= status_in;
      irq_ff      <= irq_in;
      drop_ff     <= drop_in;
      free_ff     <= free_in;
      got_cnt_ff  <= got_cnt_in;
      got_sel_ff  <= got_sel_in;
      tx_valid_ff <= tx_valid_in;
      tx_cnt_ff   <= tx_cnt_in;
      tx_hi_ff    <= tx_hi_in;
      tx_lo_ff    <= tx_lo_in;
   end

   hcf_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr_in),
      .rd_data (ram_rdata)
   );

   hcf_pack u_pack (
      .clock     (clock),
      .ctl       (pack_ctl),
      .byte_in   (ram_rdata),
      .word_high (pack_hi),
      .word_low  (pack_lo)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_irq_pulse     = irq_ff;
   assign rsp_byte_dropped  = drop_ff;
   assign rsp_free_space    = free_ff;
   assign rsp_got_count     = got_cnt_ff;
   assign rsp_got_word_high = got_sel_ff ? pack_hi : 64'd0;
   assign rsp_got_word_low  = got_sel_ff ? pack_lo : 64'd0;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_count      = tx_cnt_ff;
   assign rsp_tx_word_high  = tx_hi_ff;
   assign rsp_tx_word_low   = tx_lo_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_OW)
      else $error("ring fill count above depth");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hcf_pkg::ST_DRAIN) |-> (cnt_ff < hcf_pkg::XFER_MAX) && (used_ff != '0))
      else $error("drain running past its limit");

   a_empty_get: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == hcf_pkg::FUNC_GET) && (used_ff == '0))
         |=> rsp_valid && (rsp_got_count == 5'd0) && !busy)
      else $error("get on empty ring did not answer at once");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_got_count != 5'd0)) |-> !rsp_tx_valid && !rsp_status && !rsp_irq_pulse)
      else $error("get beat carries fields of another function");

endmodule

@@ sim/hypervisor_console_fifo_unit_checker.sv @@
`timescale 1ns / 1ps

module hypervisor_console_fifo_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_put_count,
   input  logic [63:0] req_put_word_high,
   input  logic [63:0] req_put_word_low,
   input  logic        rsp_valid,
   input  logic        rsp_status,
   input  logic        rsp_irq_pulse,
   input  logic        rsp_byte_dropped,
   input  logic [4:0]  rsp_free_space,
   input  logic [4:0]  rsp_got_count,
   input  logic [63:0] rsp_got_word_high,
   input  logic [63:0] rsp_got_word_low,
   input  logic        rsp_tx_valid,
   input  logic [4:0]  rsp_tx_count,
   input  logic [63:0] rsp_tx_word_high,
   input  logic [63:0] rsp_tx_word_low,
   output int          pending_beats,
   output int          fault_count
);

   localparam logic [4:0] DEPTH = 5'd16;

   typedef struct packed {
      logic        status;
      logic        irq_pulse;
      logic        byte_dropped;
      logic [4:0]  free_space;
      logic [4:0]  got_count;
      logic [63:0] got_hi;
      logic [63:0] got_lo;
      logic        tx_valid;
      logic [4:0]  tx_count;
      logic [63:0] tx_hi;
      logic [63:0] tx_lo;
   } console_reply_t;

   // shadow of the receive ring; pointers run modulo twice the depth
   logic [7:0] ring_copy [0:15];
   logic [4:0] wr_ptr;
   logic [4:0] rd_ptr;

   console_reply_t awaited_replies [$];

   task automatic flag_fault(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] seen,
                              input logic [63:0] want);
      if (seen !== want)
         flag_fault($sformatf("%s got %h expected %h", name, seen, want));
   endtask

   task automatic console_reply(input logic [1:0] func, input logic [7:0] rx,
                                input logic [7:0] cnt, input logic [63:0] hi,
                                input logic [63:0] lo, output console_reply_t r);
      logic [4:0] used;
      logic [4:0] n;
      logic [7:0] c;
      logic [7:0] got [0:15];
      logic       stop;
      int         k;
      r = '0;
      used = wr_ptr - rd_ptr;
      case (func)
         hcf_pkg::FUNC_HOST: begin
            if (used >= DEPTH) begin
               r.byte_dropped = 1'b1;
            end else begin
               r.irq_pulse = (used == 5'd0);
               ring_copy[wr_ptr[3:0]] = rx;
               wr_ptr++;
            end
         end
         hcf_pkg::FUNC_GET: begin
            for (k = 0; k < 16; k++)
               got[k[3:0]] = 8'h00;
            n = 5'd0;
            stop = 1'b0;
            while (!stop && n < hcf_pkg::XFER_MAX && wr_ptr != rd_ptr) begin
               c = ring_copy[rd_ptr[3:0]];
               // hold a NUL that directly follows a returned CR
               if (n != 5'd0 && got[n[3:0] - 4'd1] == hcf_pkg::CH_CR
                   && c == hcf_pkg::CH_NUL) begin
                  stop = 1'b1;
               end else begin
                  got[n[3:0]] = c;
                  n++;
                  rd_ptr++;
               end
            end
            r.got_count = n;
            for (k = 0; k < 8; k++) begin
               r.got_hi = {r.got_hi[55:0], got[k[3:0]]};
               r.got_lo = {r.got_lo[55:0], got[4'(k + 8)]};
            end
         end
         hcf_pkg::FUNC_PUT: begin
            if (cnt > {3'b000, hcf_pkg::XFER_MAX}) begin
               r.status = 1'b1;
            end else begin
               r.tx_valid = 1'b1;
               r.tx_count = cnt[4:0];
               r.tx_hi = hi;
               r.tx_lo = lo;
            end
         end
         default: ;
      endcase
      used = wr_ptr - rd_ptr;
      r.free_space = (used >= DEPTH) ? 5'd0 : DEPTH - used;
   endtask

   always @(posedge clock) begin : watch
      console_reply_t want;
      console_reply_t fresh;
      if (reset) begin
         wr_ptr = 5'd0;
         rd_ptr = 5'd0;
         awaited_replies.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (awaited_replies.size() == 0) begin
               flag_fault("result beat with nothing pending");
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", 64'(rsp_status), 64'(want.status));
               check_field("irq_pulse", 64'(rsp_irq_pulse), 64'(want.irq_pulse));
               check_field("byte_dropped", 64'(rsp_byte_dropped), 64'(want.byte_dropped));
               check_field("free_space", 64'(rsp_free_space), 64'(want.free_space));
               check_field("got_count", 64'(rsp_got_count), 64'(want.got_count));
               check_field("got_word_high", rsp_got_word_high, want.got_hi);
               check_field("got_word_low", rsp_got_word_low, want.got_lo);
               check_field("tx_valid", 64'(rsp_tx_valid), 64'(want.tx_valid));
               check_field("tx_count", 64'(rsp_tx_count), 64'(want.tx_count));
               check_field("tx_word_high", rsp_tx_word_high, want.tx_hi);
               check_field("tx_word_low", rsp_tx_word_low, want.tx_lo);
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            console_reply(req_func, req_rx_byte, req_put_count, req_put_word_high,
                          req_put_word_low, fresh);
            awaited_replies.push_back(fresh);
         end
      end
      pending_beats <= awaited_replies.size();
   end

endmodule

@@ sim/hypervisor_console_fifo_unit_tb.sv @@
`timescale 1ns / 1ps

module hypervisor_console_fifo_unit_tb;

   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1350;
   localparam int TAIL_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [7:0]  req_rx_byte;
   logic [7:0]  req_put_count;
   logic [63:0] req_put_word_high;
   logic [63:0] req_put_word_low;
   logic        rsp_valid;
   logic        rsp_status;
   logic        rsp_irq_pulse;
   logic        rsp_byte_dropped;
   logic [4:0]  rsp_free_space;
   logic [4:0]  rsp_got_count;
   logic [63:0] rsp_got_word_high;
   logic [63:0] rsp_got_word_low;
   logic        rsp_tx_valid;
   logic [4:0]  rsp_tx_count;
   logic [63:0] rsp_tx_word_high;
   logic [63:0] rsp_tx_word_low;

   int pending_beats;
   int fault_count;
   int cycle_count = 0;
   int idle_pct = 0;

   hypervisor_console_fifo_unit dut (.*);

   hypervisor_console_fifo_unit_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // lean on CR and NUL so the early stop on a get shows up often
   function automatic logic [7:0] console_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 20)
         return hcf_pkg::CH_CR;
      else if (pick < 40)
         return hcf_pkg::CH_NUL;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_beat(input logic [1:0] func, input logic [7:0] rx,
                            input logic [7:0] cnt, input logic [63:0] hi,
                            input logic [63:0] lo);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_func          <= func;
      req_rx_byte       <= rx;
      req_put_count     <= cnt;
      req_put_word_high <= hi;
      req_put_word_low  <= lo;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   initial begin
      int          idx;
      int unsigned pick;
      logic [7:0]  cnt;
      start             <= 1'b0;
      reset             <= 1'b1;
      req_func          <= hcf_pkg::FUNC_HOST;
      req_rx_byte       <= 8'h00;
      req_put_count     <= 8'h00;
      req_put_word_high <= 64'h0;
      req_put_word_low  <= 64'h0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty get, put length edges, spare selector
      send_beat(hcf_pkg::FUNC_GET, 8'hFF, 8'hFF, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_PUT, 8'h00, 8'd0, 64'h0, {64{1'b1}});
      send_beat(hcf_pkg::FUNC_PUT, 8'hFF, 8'd16, {64{1'b1}}, 64'h0);
      send_beat(hcf_pkg::FUNC_PUT, 8'h00, 8'd17, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_PUT, 8'h00, 8'd255, rand_word(), rand_word());
      send_beat(FUNC_SPARE, 8'hFF, 8'd16, rand_word(), rand_word());
      // fill the ring with a CR, NUL pair near the front, then overflow it
      send_beat(hcf_pkg::FUNC_HOST, 8'hFF, 8'h00, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_HOST, hcf_pkg::CH_CR, 8'h00, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_HOST, hcf_pkg::CH_NUL, 8'h00, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_HOST, 8'h41, 8'h00, rand_word(), rand_word());
      for (idx = 0; idx < 13; idx++)
         send_beat(hcf_pkg::FUNC_HOST, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_GET, 8'h00, 8'h00, rand_word(), rand_word());
      send_beat(hcf_pkg::FUNC_GET, 8'h00, 8'h00, rand_word(), rand_word());

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         case (idx / 338)
            1:       idle_pct = 87;
            3:       idle_pct = 23;
            default: idle_pct = 0;
         endcase
         pick = $urandom_range(99);
         if (pick < 52) begin
            send_beat(hcf_pkg::FUNC_HOST, console_byte(), 8'($urandom_range(255)),
                      rand_word(), rand_word());
         end else if (pick < 77) begin
            send_beat(hcf_pkg::FUNC_GET, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      rand_word(), rand_word());
         end else if (pick < 95) begin
            cnt = ($urandom_range(99) < 85) ? 8'($urandom_range(16))
                                            : 8'($urandom_range(255, 17));
            send_beat(hcf_pkg::FUNC_PUT, 8'($urandom_range(255)), cnt,
                      rand_word(), rand_word());
         end else begin
            send_beat(FUNC_SPARE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      rand_word(), rand_word());
         end
      end
      start <= 1'b0;

      do
         @(posedge clock);
      while (pending_beats != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
